// ===== design/asp_pkg.sv =====
package asp_pkg;

   localparam int LINE_SLOTS    = 4;
   localparam int PAYLOAD_SLOTS = 4;
   localparam int SLOT_BYTES    = 64;
   localparam int REC_MAX       = SLOT_BYTES - 1;

   localparam int OFF_W   = $clog2(SLOT_BYTES);
   localparam int LSLOT_W = $clog2(LINE_SLOTS);
   localparam int PSLOT_W = $clog2(PAYLOAD_SLOTS);
   localparam int LUSED_W = $clog2(LINE_SLOTS + 1);
   localparam int PUSED_W = $clog2(PAYLOAD_SLOTS + 1);

   localparam int LRAM_DEPTH = LINE_SLOTS * (1 << OFF_W);
   localparam int PRAM_DEPTH = PAYLOAD_SLOTS * (1 << OFF_W);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int IPD_LEN  = 5;
   localparam int ERR_LEN  = 5;
   localparam int FAIL_LEN = 4;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      KIND_BYTE         = 2'd0,
      KIND_TAKE_LINE    = 2'd1,
      KIND_TAKE_PAYLOAD = 2'd2,
      KIND_CLEAR_ERR    = 2'd3
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_TAKE
   } back_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       is_cr;
      logic       is_lf;
      logic       is_gt;
      logic       is_colon;
      logic       is_digit;
      logic [3:0] dval;
   } q_entry_type;

   typedef struct packed {
      logic last;
      logic from_payload;
      logic nothing_waiting;
      logic err;
   } rsp_meta_type;

   typedef struct packed {
      logic [7:0]   data;
      rsp_meta_type meta;
   } out_word_type;

   function automatic logic [7:0] ipd_char(input logic [2:0] idx);
      case (idx)
         3'd0:    return "+";
         3'd1:    return "I";
         3'd2:    return "P";
         3'd3:    return "D";
         3'd4:    return ",";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] err_char(input logic [2:0] idx);
      case (idx)
         3'd0:    return "E";
         3'd1:    return "R";
         3'd2:    return "R";
         3'd3:    return "O";
         3'd4:    return "R";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] fail_char(input logic [1:0] idx);
      case (idx)
         2'd0:    return "F";
         2'd1:    return "A";
         2'd2:    return "I";
         2'd3:    return "L";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [LSLOT_W-1:0] next_lslot(input logic [LSLOT_W-1:0] s);
      return (s == LSLOT_W'(LINE_SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [PSLOT_W-1:0] next_pslot(input logic [PSLOT_W-1:0] s);
      return (s == PSLOT_W'(PAYLOAD_SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

endpackage

// ===== design/asp_ram.sv =====
module asp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/asp_front.sv =====
module asp_front (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // rx_byte
   input  logic [1:0]          req_tuser,   // kind
   input  logic                q_full,
   output logic                q_push,
   output asp_pkg::q_entry_type q_entry
);
   import asp_pkg::*;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      q_entry.kind     = kind_type'(req_tuser);
      q_entry.data     = req_tdata;
      q_entry.is_cr    = (req_tdata == CH_CR);
      q_entry.is_lf    = (req_tdata == CH_LF);
      q_entry.is_gt    = (req_tdata == CH_GT);
      q_entry.is_colon = (req_tdata == CH_COLON);
      q_entry.is_digit = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
      q_entry.dval     = 4'(req_tdata - CH_ZERO);
   end

endmodule

// ===== design/asp_queue.sv =====
module asp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  asp_pkg::q_entry_type push_entry,
   output logic                full,
   output logic                head_valid,
   output asp_pkg::q_entry_type head_entry,
   input  logic                pop
);
   import asp_pkg::*;

   q_entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/asp_back.sv =====
module asp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  asp_pkg::q_entry_type q_head,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic                rsp_tlast,   // last_byte
   output logic [2:0]          rsp_tuser    // from_payload, nothing_waiting, error_seen
);
   import asp_pkg::*;

   back_state_type       state_ff, state_in;

   logic [LSLOT_W-1:0]   l_head_ff, l_head_in, l_tail_ff, l_tail_in;
   logic [LUSED_W-1:0]   l_used_ff, l_used_in, l_used_mid;
   logic [OFF_W-1:0]     l_len_ff [LINE_SLOTS];
   logic [OFF_W-1:0]     l_len_in [LINE_SLOTS];
   logic [PSLOT_W-1:0]   p_head_ff, p_head_in, p_tail_ff, p_tail_in;
   logic [PUSED_W-1:0]   p_used_ff, p_used_in, p_used_mid;
   logic [OFF_W-1:0]     p_len_ff [PAYLOAD_SLOTS];
   logic [OFF_W-1:0]     p_len_in [PAYLOAD_SLOTS];

   logic [OFF_W-1:0]     wo_ff, wo_in, wo_next, p_wo_mid;
   logic [7:0]           pl_ff, pl_in, pl_next;
   logic                 err_ff, err_in;

   logic                 ipd_ok_ff, ipd_ok_in;
   logic                 erw_ok_ff, erw_ok_in;
   logic                 fail_ok_ff, fail_ok_in;
   logic                 dig_on_ff, dig_on_in;
   logic [7:0]           val_ff, val_in;

   logic                 src_ff, src_in;
   logic [OFF_W-1:0]     k_ff, k_in, n_ff, n_in;

   logic                 l_we, p_we;
   logic [LSLOT_W+OFF_W-1:0] l_waddr, l_raddr;
   logic [PSLOT_W+OFF_W-1:0] p_waddr, p_raddr;
   logic [7:0]           l_wdata, l_rdata, p_rdata;

   logic                 l_commit;
   logic [OFF_W-1:0]     l_commit_len;
   logic                 wo_zero, l_drop, p_drop, line_short, take_last;

   logic                 issue, issue_ok, pop_out;
   rsp_meta_type         issue_meta;
   logic                 pend_ff;
   rsp_meta_type         pend_meta_ff;
   out_word_type         land, ob0_ff, ob0_in, ob1_ff, ob1_in;
   logic [1:0]           ob_cnt_ff, ob_cnt_in, occ;

   asp_ram #(.WIDTH(8), .DEPTH(LRAM_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   asp_ram #(.WIDTH(8), .DEPTH(PRAM_DEPTH)) u_payload_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (q_head.data),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   assign wo_zero    = (wo_ff == '0);
   assign l_drop     = wo_zero && (l_used_ff == LUSED_W'(LINE_SLOTS));
   assign p_drop     = wo_zero && (p_used_ff == PUSED_W'(PAYLOAD_SLOTS));
   assign l_used_mid = l_used_ff - LUSED_W'(l_drop);
   assign p_used_mid = p_used_ff - PUSED_W'(p_drop);
   assign wo_next    = wo_ff + 1'b1;
   assign p_wo_mid   = (wo_ff < OFF_W'(REC_MAX)) ? wo_next : wo_ff;
   assign pl_next    = pl_ff - 1'b1;
   assign line_short = (wo_ff < OFF_W'(IPD_LEN));
   assign take_last  = (k_ff == n_ff - 1'b1);
   assign l_raddr    = {l_head_ff, k_ff};
   assign p_raddr    = {p_head_ff, k_ff};

   assign pop_out  = rsp_tvalid && rsp_tready;
   assign occ      = ob_cnt_ff + 2'(pend_ff);
   assign issue_ok = (occ != 2'd2) || pop_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      l_head_in  = l_head_ff;
      l_tail_in  = l_tail_ff;
      l_used_in  = l_used_ff;
      l_len_in   = l_len_ff;
      p_head_in  = p_head_ff;
      p_tail_in  = p_tail_ff;
      p_used_in  = p_used_ff;
      p_len_in   = p_len_ff;
      wo_in      = wo_ff;
      pl_in      = pl_ff;
      err_in     = err_ff;
      ipd_ok_in  = ipd_ok_ff;
      erw_ok_in  = erw_ok_ff;
      fail_ok_in = fail_ok_ff;
      dig_on_in  = dig_on_ff;
      val_in     = val_ff;
      src_in     = src_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      q_pop      = 1'b0;
      l_we       = 1'b0;
      p_we       = 1'b0;
      l_waddr    = {l_tail_ff, wo_ff};
      l_wdata    = q_head.data;
      p_waddr    = {p_tail_ff, wo_ff};
      l_commit     = 1'b0;
      l_commit_len = wo_ff;
      issue      = 1'b0;
      issue_meta = '{last: 1'b0, from_payload: 1'b0, nothing_waiting: 1'b0, err: err_ff};

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_head.kind)
                  KIND_BYTE: begin
                     q_pop = 1'b1;
                     if (pl_ff != '0) begin
                        if (p_drop) begin
                           p_head_in = next_pslot(p_head_ff);
                        end
                        p_we = (wo_ff < OFF_W'(REC_MAX));
                        pl_in = pl_next;
                        if (pl_next == '0) begin
                           p_len_in[p_tail_ff] = p_wo_mid;
                           p_used_in = p_used_mid + 1'b1;
                           p_tail_in = next_pslot(p_tail_ff);
                           wo_in     = '0;
                        end else begin
                           p_used_in = p_used_mid;
                           wo_in     = p_wo_mid;
                        end
                     end else begin
                        if (l_drop) begin
                           l_head_in = next_lslot(l_head_ff);
                        end
                        l_used_in = l_used_mid;
                        if (q_head.is_cr) begin
                           l_used_in = l_used_mid;
                        end else if (q_head.is_lf) begin
                           l_commit = !wo_zero;
                        end else if (q_head.is_gt && wo_zero) begin
                           l_we         = 1'b1;
                           l_commit     = 1'b1;
                           l_commit_len = OFF_W'(1);
                        end else if (q_head.is_colon && !line_short && ipd_ok_ff) begin
                           pl_in = val_ff;
                           wo_in = '0;
                        end else begin
                           l_we       = 1'b1;
                           ipd_ok_in  = (wo_zero || ipd_ok_ff) &&
                                        (!line_short || q_head.data == ipd_char(wo_ff[2:0]));
                           erw_ok_in  = (wo_zero || erw_ok_ff) &&
                                        (wo_ff < OFF_W'(ERR_LEN)) &&
                                        (q_head.data == err_char(wo_ff[2:0]));
                           fail_ok_in = (wo_zero || fail_ok_ff) &&
                                        (wo_ff < OFF_W'(FAIL_LEN)) &&
                                        (q_head.data == fail_char(wo_ff[1:0]));
                           if (line_short) begin
                              dig_on_in = 1'b1;
                              val_in    = '0;
                           end else if (dig_on_ff && q_head.is_digit) begin
                              val_in = 8'({val_ff[4:0], 3'b000}) + 8'({val_ff[6:0], 1'b0})
                                       + 8'(q_head.dval);
                           end else begin
                              dig_on_in = 1'b0;
                           end
                           if (wo_next == OFF_W'(REC_MAX)) begin
                              l_commit     = 1'b1;
                              l_commit_len = wo_next;
                           end else begin
                              wo_in = wo_next;
                           end
                        end
                        if (l_commit) begin
                           l_len_in[l_tail_ff] = l_commit_len;
                           if ((l_commit_len == OFF_W'(ERR_LEN) && erw_ok_ff) ||
                               (l_commit_len == OFF_W'(FAIL_LEN) && fail_ok_ff)) begin
                              err_in = 1'b1;
                           end
                           l_used_in = l_used_mid + 1'b1;
                           l_tail_in = next_lslot(l_tail_ff);
                           wo_in     = '0;
                        end
                     end
                  end
                  KIND_TAKE_LINE, KIND_TAKE_PAYLOAD: begin
                     if (issue_ok) begin
                        q_pop  = 1'b1;
                        src_in = (q_head.kind == KIND_TAKE_PAYLOAD);
                        if ((src_in && p_used_ff == '0) || (!src_in && l_used_ff == '0)) begin
                           issue = 1'b1;
                           issue_meta.nothing_waiting = 1'b1;
                        end else begin
                           state_in = BK_TAKE;
                           k_in     = '0;
                           n_in     = src_in ? p_len_ff[p_head_ff] : l_len_ff[l_head_ff];
                        end
                     end
                  end
                  KIND_CLEAR_ERR: begin
                     q_pop  = 1'b1;
                     err_in = 1'b0;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_TAKE: begin
            if (issue_ok) begin
               issue = 1'b1;
               issue_meta.from_payload = src_ff;
               issue_meta.last         = take_last;
               if (take_last) begin
                  state_in = BK_IDLE;
                  if (src_ff) begin
                     p_head_in = next_pslot(p_head_ff);
                     p_used_in = p_used_ff - 1'b1;
                  end else begin
                     l_head_in = next_lslot(l_head_ff);
                     l_used_in = l_used_ff - 1'b1;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_head_ff <= '0;
         l_tail_ff <= '0;
         l_used_ff <= '0;
         p_head_ff <= '0;
         p_tail_ff <= '0;
         p_used_ff <= '0;
         wo_ff     <= '0;
         pl_ff     <= '0;
         err_ff    <= 1'b0;
         pend_ff   <= 1'b0;
         ob_cnt_ff <= '0;
         for (int i = 0; i < LINE_SLOTS; i++) begin
            l_len_ff[i] <= '0;
         end
         for (int i = 0; i < PAYLOAD_SLOTS; i++) begin
            p_len_ff[i] <= '0;
         end
      end else begin
         l_head_ff <= l_head_in;
         l_tail_ff <= l_tail_in;
         l_used_ff <= l_used_in;
         p_head_ff <= p_head_in;
         p_tail_ff <= p_tail_in;
         p_used_ff <= p_used_in;
         wo_ff     <= wo_in;
         pl_ff     <= pl_in;
         err_ff    <= err_in;
         pend_ff   <= issue;
         ob_cnt_ff <= ob_cnt_in;
         l_len_ff  <= l_len_in;
         p_len_ff  <= p_len_in;
      end
   end

   always_ff @(posedge clock) begin
      ipd_ok_ff  <= ipd_ok_in;
      erw_ok_ff  <= erw_ok_in;
      fail_ok_ff <= fail_ok_in;
      dig_on_ff  <= dig_on_in;
      val_ff     <= val_in;
      src_ff     <= src_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      ob0_ff     <= ob0_in;
      ob1_ff     <= ob1_in;
      if (issue) begin
         pend_meta_ff <= issue_meta;
      end
   end

   always_comb begin
      land.meta = pend_meta_ff;
      if (pend_meta_ff.nothing_waiting) begin
         land.data = 8'h00;
      end else if (pend_meta_ff.from_payload) begin
         land.data = p_rdata;
      end else begin
         land.data = l_rdata;
      end
   end

   always_comb begin
      ob0_in    = ob0_ff;
      ob1_in    = ob1_ff;
      ob_cnt_in = ob_cnt_ff;
      if (pop_out && pend_ff) begin
         if (ob_cnt_ff == 2'd2) begin
            ob0_in = ob1_ff;
            ob1_in = land;
         end else begin
            ob0_in = land;
         end
      end else if (pop_out) begin
         ob0_in    = ob1_ff;
         ob_cnt_in = ob_cnt_ff - 1'b1;
      end else if (pend_ff) begin
         if (ob_cnt_ff == 2'd0) begin
            ob0_in = land;
         end else begin
            ob1_in = land;
         end
         ob_cnt_in = ob_cnt_ff + 1'b1;
      end
   end

   assign rsp_tvalid = (ob_cnt_ff != 2'd0);
   assign rsp_tdata  = ob0_ff.data;
   assign rsp_tlast  = ob0_ff.meta.last;
   assign rsp_tuser  = {ob0_ff.meta.err, ob0_ff.meta.nothing_waiting,
                        ob0_ff.meta.from_payload};

   a_line_used_bound: assert property (@(posedge clock) disable iff (reset)
      l_used_ff <= LUSED_W'(LINE_SLOTS))
      else $error("line ring count beyond slot count");

   a_payload_used_bound: assert property (@(posedge clock) disable iff (reset)
      p_used_ff <= PUSED_W'(PAYLOAD_SLOTS))
      else $error("payload ring count beyond slot count");

   a_out_space: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, ob_cnt_ff} + 3'(pend_ff)) <= 3'd2)
      else $error("output buffer overrun");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_TAKE |-> ((src_ff && p_used_ff != '0) || (!src_ff && l_used_ff != '0)))
      else $error("take running on an empty ring");

   a_line_offset: assert property (@(posedge clock) disable iff (reset)
      pl_ff == '0 |-> wo_ff < OFF_W'(REC_MAX))
      else $error("line offset reached record limit");

endmodule

// ===== design/at_response_line_and_payload_splitter.sv =====
// Byte and clear-error words: one per cycle while the queue has room, run from the queue head.
// Take words: the back end enters its take state and reads the record, one character per
//   cycle while the output buffer has room, from that ring's RAM read port (an empty ring
//   gives one nothing-waiting word); the back end stays in the take to the last character.
// Reset (synchronous, active high) clears ring pointers, counts, record lengths, the error
//   flag, the queue and the output buffer; RAM contents stay undefined until written.
module at_response_line_and_payload_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte
   input  logic [1:0] req_tuser,   // kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast,   // last_byte
   output logic [2:0] rsp_tuser    // from_payload, nothing_waiting, error_seen
);
   import asp_pkg::*;

   q_entry_type push_entry, head_entry;
   logic        q_push, q_full, q_valid, q_pop;

   asp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   asp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (head_entry),
      .pop        (q_pop)
   );

   asp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
